// ===== src/vor_pkg.sv =====
package vor_pkg;

  // Q2.16 coefficients, wide enough to hold +-1.0
  localparam int unsigned CoefW   = 18;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CodeW   = 5;
  localparam int unsigned NumCode = 32;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef coef_t [2:0] coef_row_t;
  typedef logic [CodeW-1:0] rot_code_t;

  localparam rot_code_t RotNone = 5'd0;

  // pipeline advance strobes shared by the row datapaths
  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } vor_adv_t;

  localparam coef_t Z  = 18'sd0;
  localparam coef_t P1 = 18'sd65536;
  localparam coef_t PH = 18'sd46341;
  localparam coef_t N1 = -P1;
  localparam coef_t NH = -PH;

  // one row-major 3x3 matrix per orientation code
  localparam coef_t RotMat [NumCode][9] = '{
    '{P1, Z,  Z,  Z,  P1, Z,  Z,  Z,  P1},
    '{PH, NH, Z,  PH, PH, Z,  Z,  Z,  P1},
    '{Z,  N1, Z,  P1, Z,  Z,  Z,  Z,  P1},
    '{NH, NH, Z,  PH, NH, Z,  Z,  Z,  P1},
    '{N1, Z,  Z,  Z,  N1, Z,  Z,  Z,  P1},
    '{NH, PH, Z,  NH, NH, Z,  Z,  Z,  P1},
    '{Z,  P1, Z,  N1, Z,  Z,  Z,  Z,  P1},
    '{PH, PH, Z,  NH, PH, Z,  Z,  Z,  P1},
    '{P1, Z,  Z,  Z,  N1, Z,  Z,  Z,  N1},
    '{PH, PH, Z,  PH, NH, Z,  Z,  Z,  N1},
    '{Z,  P1, Z,  P1, Z,  Z,  Z,  Z,  N1},
    '{NH, PH, Z,  PH, PH, Z,  Z,  Z,  N1},
    '{N1, Z,  Z,  Z,  P1, Z,  Z,  Z,  N1},
    '{NH, NH, Z,  NH, PH, Z,  Z,  Z,  N1},
    '{Z,  N1, Z,  N1, Z,  Z,  Z,  Z,  N1},
    '{PH, NH, Z,  NH, NH, Z,  Z,  Z,  N1},
    '{P1, Z,  Z,  Z,  Z,  N1, Z,  P1, Z },
    '{PH, Z,  PH, PH, Z,  NH, Z,  P1, Z },
    '{Z,  Z,  P1, P1, Z,  Z,  Z,  P1, Z },
    '{NH, Z,  PH, PH, Z,  PH, Z,  P1, Z },
    '{P1, Z,  Z,  Z,  Z,  P1, Z,  N1, Z },
    '{PH, Z,  NH, PH, Z,  PH, Z,  N1, Z },
    '{Z,  Z,  N1, P1, Z,  Z,  Z,  N1, Z },
    '{NH, Z,  NH, PH, Z,  NH, Z,  N1, Z },
    '{Z,  Z,  P1, N1, Z,  Z,  Z,  N1, Z },
    '{Z,  Z,  P1, Z,  P1, Z,  N1, Z,  Z },
    '{Z,  Z,  N1, Z,  P1, Z,  P1, Z,  Z },
    '{Z,  Z,  P1, Z,  N1, Z,  P1, Z,  Z },
    '{Z,  Z,  P1, Z,  N1, Z,  P1, Z,  Z },
    '{Z,  P1, Z,  Z,  Z,  N1, N1, Z,  Z },
    '{18'sd9374, 18'sd24168, -18'sd60191,
      -18'sd21767, -18'sd56118, -18'sd25923,
      -18'sd61101, 18'sd23699, Z},
    '{Z,  N1, Z,  Z,  Z,  P1, N1, Z,  Z }
  };

endpackage

// ===== src/vor_row.sv =====
module vor_row #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  vor_pkg::vor_adv_t            adv_i,
  input  logic signed [DATA_WIDTH-1:0] x_i,
  input  logic signed [DATA_WIDTH-1:0] y_i,
  input  logic signed [DATA_WIDTH-1:0] z_i,
  input  vor_pkg::coef_row_t           coef_i,
  output logic signed [DATA_WIDTH-1:0] val_o,
  output logic                         clip_o
);
  import vor_pkg::*;

  localparam int unsigned ProdW = DATA_WIDTH + CoefW;
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned RndW  = SumW - FracW;
  localparam logic [SumW-1:0] Half = SumW'(1) << (FracW - 1);

  logic signed [DATA_WIDTH-1:0] src [3];
  logic signed [ProdW-1:0]      prod_d [3];
  logic signed [ProdW-1:0]      prod_q [3];
  logic signed [SumW-1:0]       sum_d, sum_q;
  logic signed [RndW-1:0]       rnd;
  logic                         ovf_hi, ovf_lo;

  assign src[0] = x_i;
  assign src[1] = y_i;
  assign src[2] = z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = ProdW'(src[i]) * ProdW'(coef_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // exact sum plus half an lsb, so the floor below rounds half up
  assign sum_d = SumW'(prod_q[0]) + SumW'(prod_q[1]) + SumW'(prod_q[2]) + signed'(Half);

  always_ff @(posedge clk_i) begin
    if (adv_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  assign rnd = sum_q[SumW-1:FracW];

  // out of range when the result's sign bit and the bits above are not all alike
  assign ovf_hi = !rnd[RndW-1] && (rnd[RndW-2:DATA_WIDTH-1] != '0);
  assign ovf_lo = rnd[RndW-1] && (rnd[RndW-2:DATA_WIDTH-1] != '1);

  always_comb begin
    if (ovf_hi) begin
      val_o = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else if (ovf_lo) begin
      val_o = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      val_o = rnd[DATA_WIDTH-1:0];
    end
  end

  assign clip_o = ovf_hi || ovf_lo;

endmodule

// ===== src/vector_orientation_rotate.sv =====
// channel  direction  handshake                  word
// in       sink       in_valid_i / in_stall_o    in_x_i, in_y_i, in_z_i
// out      source     out_valid_o / out_stall_i  out_x_o, out_y_o, out_z_o, clipped_o
// cfg      sink       cfg_we_i                   cfg_data_i (rotation code)
//
// four register stages: input, products, row sums, rounded and saturated output.
// one word per cycle sustained while out_stall_i is low; a taken word moves through the stages in that order.
// reset clears the stage valid bits and sets the rotation code to none.
// a stall at the output holds the last stage; earlier stages keep filling bubbles,
// so the input stalls only when every stage holds a word.
module vector_orientation_rotate #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  vor_pkg::rot_code_t           cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] in_x_i,
  input  logic signed [DATA_WIDTH-1:0] in_y_i,
  input  logic signed [DATA_WIDTH-1:0] in_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] out_x_o,
  output logic signed [DATA_WIDTH-1:0] out_y_o,
  output logic signed [DATA_WIDTH-1:0] out_z_o,
  output logic                         clipped_o
);
  import vor_pkg::*;

  rot_code_t code_q;
  logic      v1_q, v2_q, v3_q, v4_q;
  logic      rdy1, rdy2, rdy3, rdy4;
  vor_adv_t  adv;

  logic signed [DATA_WIDTH-1:0] x_q, y_q, z_q;
  logic signed [DATA_WIDTH-1:0] row_val [3];
  logic                         row_clip [3];
  coef_row_t                    row_coef [3];

  logic signed [DATA_WIDTH-1:0] out_x_q, out_y_q, out_z_q;
  logic                         clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= RotNone;
    end else if (cfg_we_i) begin
      code_q <= cfg_data_i;
    end
  end

  // a stage moves when it is empty or the one after it moves
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign adv.mul_en = rdy2 && v1_q;
  assign adv.sum_en = rdy3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      x_q <= in_x_i;
      y_q <= in_y_i;
      z_q <= in_z_i;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        row_coef[r][i] = RotMat[code_q][3*r+i];
      end
    end

    vor_row #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_row (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .x_i    (x_q),
      .y_i    (y_q),
      .z_i    (z_q),
      .coef_i (row_coef[r]),
      .val_o  (row_val[r]),
      .clip_o (row_clip[r])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      out_x_q <= row_val[0];
      out_y_q <= row_val[1];
      out_z_q <= row_val[2];
      clip_q  <= row_clip[0] || row_clip[1] || row_clip[2];
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v4_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign clipped_o   = clip_q;

  localparam logic signed [DATA_WIDTH-1:0] MaxV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MinV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // a flagged word must carry at least one rail value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      (out_x_o == MaxV) || (out_x_o == MinV) || (out_y_o == MaxV) ||
      (out_y_o == MinV) || (out_z_o == MaxV) || (out_z_o == MinV))
    else $error("clipped word without a saturated component");

  // the input only backs up once every stage holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && v1_q && v2_q && v3_q)
    else $error("input stalled with a bubble in the pipeline");

  // a word in the sum stage reaches the output stage on the next move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && rdy4 |=> out_valid_o)
    else $error("word lost between sum and output stage");

endmodule
